>>> rtl/core/fti_pkg.sv
package fti_pkg;

    // field widths
    localparam int RATING_W   = 12;
    localparam int RATING_MAX = 2560;
    localparam int CENT_W     = 15;
    localparam int CFG_IDX_W  = 2;

    // membership format, unsigned Q.M with 1.0 = 2^M
    localparam int MEM_FRAC = 12;
    localparam int MEM_W    = MEM_FRAC + 1;
    localparam logic [MEM_W-1:0] MEM_ONE = MEM_W'(1) << MEM_FRAC;

    // food shoulder breakpoints in rating LSBs
    localparam int FOOD_POOR_FULL = 512;
    localparam int FOOD_POOR_ZERO = 1024;
    localparam int FOOD_EXC_ZERO  = 1536;
    localparam int FOOD_EXC_FULL  = 2048;
    localparam int RAMP_SHIFT     = 9;

    // service centres
    localparam int SVC_GOOD_CENTRE = 1280;

    // Gaussian table
    localparam int GAUSS_DEPTH = 256;
    localparam int GIDX_W      = $clog2(GAUSS_DEPTH);

    // index = floor(d * DEPTH / scale) done as multiply by a rounded-up reciprocal
    localparam int IDX_SHIFT = 25;
    localparam longint unsigned SCALE_POOR = 3072;
    localparam longint unsigned SCALE_WIDE = 5120;
    localparam longint unsigned RCP_POOR =
        (longint'(GAUSS_DEPTH) * (64'd1 << IDX_SHIFT) + SCALE_POOR - 1) / SCALE_POOR;
    localparam longint unsigned RCP_WIDE =
        (longint'(GAUSS_DEPTH) * (64'd1 << IDX_SHIFT) + SCALE_WIDE - 1) / SCALE_WIDE;
    localparam int RCP_W  = $clog2(RCP_POOR + 1);
    localparam int PROD_W = RATING_W + RCP_W;
    localparam int QIDX_W = PROD_W - IDX_SHIFT;

    // weighted sum and division
    localparam int WPROD_W = MEM_W + CENT_W;
    localparam int DEN_W   = MEM_W + 2;
    localparam int NUM_W   = WPROD_W + 2;
    localparam int QUO_W   = CENT_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_TIP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_TIP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIP = 2'd2;

    localparam logic [CENT_W-1:0] LOW_TIP_RESET  = 15'd1280;
    localparam logic [CENT_W-1:0] MID_TIP_RESET  = 15'd3840;
    localparam logic [CENT_W-1:0] HIGH_TIP_RESET = 15'd6400;

    // classified item handed from front to back
    typedef struct packed {
        logic [MEM_W-1:0]    f_poor;
        logic [MEM_W-1:0]    f_exc;
        logic [RATING_W-1:0] d_poor;
        logic [RATING_W-1:0] d_good;
        logic [RATING_W-1:0] d_exc;
    } fti_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fti_qstat_t;

    typedef logic [MEM_W-1:0] gauss_rom_t [GAUSS_DEPTH];

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned DEPTH_SQ = longint'(GAUSS_DEPTH) * longint'(GAUSS_DEPTH);

    // exp(-z^2/2) for z = 8k/DEPTH: Taylor series for exp(-z^2/512) in Q30,
    // then squared eight times, rounded to Q.M
    function automatic gauss_rom_t build_gauss_rom();
        gauss_rom_t rom;
        longint unsigned b;
        longint unsigned v;
        longint unsigned kk;
        for (int k = 0; k < GAUSS_DEPTH; k++)
        begin
            kk = longint'(k);
            b = ((kk * kk) << 27) / DEPTH_SQ;
            v = Q30_ONE;
            v = Q30_ONE - (((b / 8) * v) >> 30);
            v = Q30_ONE - (((b / 7) * v) >> 30);
            v = Q30_ONE - (((b / 6) * v) >> 30);
            v = Q30_ONE - (((b / 5) * v) >> 30);
            v = Q30_ONE - (((b / 4) * v) >> 30);
            v = Q30_ONE - (((b / 3) * v) >> 30);
            v = Q30_ONE - (((b / 2) * v) >> 30);
            v = Q30_ONE - ((b * v) >> 30);
            for (int i = 0; i < 8; i++)
            begin
                v = (v * v) >> 30;
            end
            v = (v + (64'd1 << (29 - MEM_FRAC))) >> (30 - MEM_FRAC);
            rom[k] = v[MEM_W-1:0];
        end
        return rom;
    endfunction

    localparam gauss_rom_t GAUSS_ROM = build_gauss_rom();

endpackage

>>> rtl/core/fti_front.sv
module fti_front import fti_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [RATING_W-1:0] food_rating,
    input  logic [RATING_W-1:0] service_rating,
    input  fti_qstat_t          q_stat,
    output logic                push,
    output fti_item_t           item
);

    logic                front_valid_reg;
    logic                front_valid_next;
    fti_item_t           item_reg;
    fti_item_t           item_next;
    logic [RATING_W-1:0] food_sat;
    logic [RATING_W-1:0] svc_sat;
    logic [9:0]          poor_diff;
    logic [9:0]          exc_diff;
    logic [10+MEM_FRAC-1:0] poor_ramp;
    logic [10+MEM_FRAC-1:0] exc_ramp;
    logic                accept;

    assign push     = front_valid_reg && !q_stat.full;
    assign in_ready = !front_valid_reg || !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign item     = item_reg;

    // saturate ratings
    assign food_sat = (food_rating > RATING_W'(RATING_MAX)) ? RATING_W'(RATING_MAX) : food_rating;
    assign svc_sat  = (service_rating > RATING_W'(RATING_MAX)) ?
                      RATING_W'(RATING_MAX) : service_rating;

    // food shoulder ramps
    assign poor_diff = 10'(RATING_W'(FOOD_POOR_ZERO) - food_sat);
    assign exc_diff  = 10'(food_sat - RATING_W'(FOOD_EXC_ZERO));
    assign poor_ramp = {poor_diff, {MEM_FRAC{1'b0}}} >> RAMP_SHIFT;
    assign exc_ramp  = {exc_diff, {MEM_FRAC{1'b0}}} >> RAMP_SHIFT;

    // classify: food memberships and service distances
    always_comb
    begin
        if (food_sat <= RATING_W'(FOOD_POOR_FULL))
        begin
            item_next.f_poor = MEM_ONE;
        end
        else if (food_sat <= RATING_W'(FOOD_POOR_ZERO))
        begin
            item_next.f_poor = poor_ramp[MEM_W-1:0];
        end
        else
        begin
            item_next.f_poor = '0;
        end
        if (food_sat <= RATING_W'(FOOD_EXC_ZERO))
        begin
            item_next.f_exc = '0;
        end
        else if (food_sat <= RATING_W'(FOOD_EXC_FULL))
        begin
            item_next.f_exc = exc_ramp[MEM_W-1:0];
        end
        else
        begin
            item_next.f_exc = MEM_ONE;
        end
        item_next.d_poor = svc_sat;
        item_next.d_good = (svc_sat > RATING_W'(SVC_GOOD_CENTRE)) ?
                           svc_sat - RATING_W'(SVC_GOOD_CENTRE) :
                           RATING_W'(SVC_GOOD_CENTRE) - svc_sat;
        item_next.d_exc  = RATING_W'(RATING_MAX) - svc_sat;
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> rtl/core/fti_queue.sv
module fti_queue import fti_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  fti_item_t  push_item,
    input  logic       pop,
    output fti_item_t  pop_item,
    output fti_qstat_t q_stat
);

    fti_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] wptr_next;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W-1:0] rptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_item     = mem_reg[rptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/fti_div.sv
module fti_div import fti_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             zero,
    output logic             out_vld,
    output logic [QUO_W-1:0] quo,
    output logic             out_zero
);

    // one quotient bit per stage, most significant first
    logic             vld_reg  [QUO_W];
    logic [NUM_W-1:0] rem_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic             zero_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int BITPOS = QUO_W - 1 - s;
        logic             vld_prev;
        logic [NUM_W-1:0] rem_prev;
        logic [DEN_W-1:0] den_prev;
        logic [QUO_W-1:0] quo_prev;
        logic             zero_prev;
        logic [NUM_W:0]   trial;
        logic             ge;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign vld_prev  = in_vld;
            assign rem_prev  = num;
            assign den_prev  = den;
            assign quo_prev  = '0;
            assign zero_prev = zero;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign den_prev  = den_reg[s-1];
            assign quo_prev  = quo_reg[s-1];
            assign zero_prev = zero_reg[s-1];
        end

        // trial subtract of the shifted divisor
        always_comb
        begin
            trial    = (NUM_W + 1)'(den_prev) << BITPOS;
            ge       = ({1'b0, rem_prev} >= trial);
            rem_next = ge ? NUM_W'({1'b0, rem_prev} - trial) : rem_prev;
            quo_next = quo_prev;
            quo_next[BITPOS] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[s] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_prev;
                quo_reg[s]  <= quo_next;
                zero_reg[s] <= zero_prev;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign quo      = quo_reg[QUO_W-1];
    assign out_zero = zero_reg[QUO_W-1];

endmodule

>>> rtl/core/fti_back.sv
module fti_back import fti_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  fti_qstat_t        q_stat,
    input  fti_item_t         q_item,
    output logic              pop,
    input  logic [CENT_W-1:0] low_cent,
    input  logic [CENT_W-1:0] mid_cent,
    input  logic [CENT_W-1:0] high_cent,
    output logic              res_vld,
    output logic [QUO_W-1:0]  res_quo,
    output logic              res_zero
);

    // stage 1: index products
    logic              s1_vld_reg;
    logic [MEM_W-1:0]  s1_f_poor_reg;
    logic [MEM_W-1:0]  s1_f_exc_reg;
    logic [PROD_W-1:0] s1_p_poor_reg;
    logic [PROD_W-1:0] s1_p_good_reg;
    logic [PROD_W-1:0] s1_p_exc_reg;
    // stage 2: rule strengths
    logic              s2_vld_reg;
    logic [MEM_W-1:0]  s2_w_lo_reg;
    logic [MEM_W-1:0]  s2_w_mid_reg;
    logic [MEM_W-1:0]  s2_w_hi_reg;
    // stage 3: weighted centroids
    logic               s3_vld_reg;
    logic [WPROD_W-1:0] s3_m_lo_reg;
    logic [WPROD_W-1:0] s3_m_mid_reg;
    logic [WPROD_W-1:0] s3_m_hi_reg;
    logic [DEN_W-1:0]   s3_den_reg;
    // stage 4: numerator with rounding term
    logic              s4_vld_reg;
    logic [NUM_W-1:0]  s4_num_reg;
    logic [DEN_W-1:0]  s4_den_reg;
    logic              s4_zero_reg;

    logic [QIDX_W-1:0] i_poor;
    logic [QIDX_W-1:0] i_good;
    logic [QIDX_W-1:0] i_exc;
    logic [MEM_W-1:0]  g_poor;
    logic [MEM_W-1:0]  g_good;
    logic [MEM_W-1:0]  g_exc;

    assign pop = advance && !q_stat.empty;

    // table index with saturation at the last entry
    function automatic logic [QIDX_W-1:0] sat_idx(input logic [PROD_W-1:0] p);
        logic [QIDX_W-1:0] q;
        q = p[PROD_W-1:IDX_SHIFT];
        if (q > QIDX_W'(GAUSS_DEPTH - 1))
        begin
            q = QIDX_W'(GAUSS_DEPTH - 1);
        end
        return q;
    endfunction

    assign i_poor = sat_idx(s1_p_poor_reg);
    assign i_good = sat_idx(s1_p_good_reg);
    assign i_exc  = sat_idx(s1_p_exc_reg);
    assign g_poor = GAUSS_ROM[i_poor[GIDX_W-1:0]];
    assign g_good = GAUSS_ROM[i_good[GIDX_W-1:0]];
    assign g_exc  = GAUSS_ROM[i_exc[GIDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg <= !q_stat.empty;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_f_poor_reg <= q_item.f_poor;
            s1_f_exc_reg  <= q_item.f_exc;
            s1_p_poor_reg <= PROD_W'(q_item.d_poor) * PROD_W'(RCP_POOR);
            s1_p_good_reg <= PROD_W'(q_item.d_good) * PROD_W'(RCP_WIDE);
            s1_p_exc_reg  <= PROD_W'(q_item.d_exc) * PROD_W'(RCP_WIDE);

            s2_w_lo_reg  <= (g_poor > s1_f_poor_reg) ? g_poor : s1_f_poor_reg;
            s2_w_mid_reg <= g_good;
            s2_w_hi_reg  <= (g_exc > s1_f_exc_reg) ? g_exc : s1_f_exc_reg;

            s3_m_lo_reg  <= WPROD_W'(s2_w_lo_reg) * WPROD_W'(low_cent);
            s3_m_mid_reg <= WPROD_W'(s2_w_mid_reg) * WPROD_W'(mid_cent);
            s3_m_hi_reg  <= WPROD_W'(s2_w_hi_reg) * WPROD_W'(high_cent);
            s3_den_reg   <= DEN_W'(s2_w_lo_reg) + DEN_W'(s2_w_mid_reg) + DEN_W'(s2_w_hi_reg);

            s4_num_reg  <= NUM_W'(s3_m_lo_reg) + NUM_W'(s3_m_mid_reg) + NUM_W'(s3_m_hi_reg)
                           + NUM_W'(s3_den_reg >> 1);
            s4_den_reg  <= s3_den_reg;
            s4_zero_reg <= (s3_den_reg == '0);
        end
    end

    fti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (s4_vld_reg),
        .num      (s4_num_reg),
        .den      (s4_den_reg),
        .zero     (s4_zero_reg),
        .out_vld  (res_vld),
        .quo      (res_quo),
        .out_zero (res_zero)
    );

endmodule

>>> rtl/core/fuzzy_two_input_inference.sv
// Channel  Direction  Signals                                     Beat
// in       sink       in_valid, in_ready, food_rating,            one rating pair
//                     service_rating
// out      source     out_valid, out_ready, tip_percent,          one tip result
//                     zero_weight_flag
// cfg      sink       cfg_valid, cfg_ready, cfg_index, cfg_data   one centroid write
//
// One pair per cycle sustained while the output is not stalled; 22 register stages
// lie between the accepting edge and the result: front register, queue, four back
// stages, fifteen divider stages, output register.
// The divider (one quotient bit per stage) sets the depth.
// Reset clears all valid state and loads the centroid reset values.
// A stalled output freezes the back pipeline; the front and its two-beat queue
// keep taking pairs until the queue fills. cfg_ready is always high.
module fuzzy_two_input_inference import fti_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RATING_W-1:0]  food_rating,
    input  logic [RATING_W-1:0]  service_rating,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CENT_W-1:0]    tip_percent,
    output logic                 zero_weight_flag,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CENT_W-1:0]    cfg_data
);

    logic              advance;
    logic              push;
    logic              pop;
    fti_item_t         front_item;
    fti_item_t         q_item;
    fti_qstat_t        q_stat;
    logic              res_vld;
    logic [QUO_W-1:0]  res_quo;
    logic              res_zero;
    logic [CENT_W-1:0] low_cent_reg;
    logic [CENT_W-1:0] mid_cent_reg;
    logic [CENT_W-1:0] high_cent_reg;
    logic              out_valid_reg;
    logic [CENT_W-1:0] tip_reg;
    logic              flag_reg;

    assign cfg_ready        = 1'b1;
    assign advance          = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign tip_percent      = tip_reg;
    assign zero_weight_flag = flag_reg;

    // centroid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cent_reg  <= LOW_TIP_RESET;
            mid_cent_reg  <= MID_TIP_RESET;
            high_cent_reg <= HIGH_TIP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOW_TIP:  low_cent_reg  <= cfg_data;
                REG_MID_TIP:  mid_cent_reg  <= cfg_data;
                REG_HIGH_TIP: high_cent_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    fti_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .food_rating    (food_rating),
        .service_rating (service_rating),
        .q_stat         (q_stat),
        .push           (push),
        .item           (front_item)
    );

    fti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (q_item),
        .q_stat    (q_stat)
    );

    fti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .q_stat    (q_stat),
        .q_item    (q_item),
        .pop       (pop),
        .low_cent  (low_cent_reg),
        .mid_cent  (mid_cent_reg),
        .high_cent (high_cent_reg),
        .res_vld   (res_vld),
        .res_quo   (res_quo),
        .res_zero  (res_zero)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tip_reg  <= res_zero ? '0 : res_quo;
            flag_reg <= res_zero;
        end
    end

`ifndef SYNTHESIS
    // a zero total weight always reports a zero tip
    a_zero_tip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_weight_flag |-> tip_percent == '0)
        else $error("zero weight result with nonzero tip");

    // input only stalls when the queue is full
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_stat.full)
        else $error("input stalled with room in queue");

    // a centroid write lands in the next cycle
    a_cfg_low: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == REG_LOW_TIP |=> low_cent_reg == $past(cfg_data))
        else $error("low centroid write lost");

    // no pop from an empty queue
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule
